// ===== rtl/bct_pkg.sv =====
`timescale 1ns / 1ps

package bct_pkg;

  // Operation codes carried by the mode field
  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_DELETE = 3'd1;
  localparam logic [2:0] MODE_SWAP   = 3'd2;
  localparam logic [2:0] MODE_BOX    = 3'd3;
  localparam logic [2:0] MODE_COUNT  = 3'd4;
  localparam logic [2:0] MODE_FIRST  = 3'd5;
  localparam logic [2:0] MODE_LAST   = 3'd6;

  // Read address select
  localparam logic [1:0] RD_PTR = 2'd0;
  localparam logic [1:0] RD_IA  = 2'd1;
  localparam logic [1:0] RD_IB  = 2'd2;

  // Write address / data select
  localparam logic [1:0] WR_APPEND = 2'd0;  // new entry at the tail
  localparam logic [1:0] WR_SHIFT  = 2'd1;  // read entry moves down one slot
  localparam logic [1:0] WR_IA_RD  = 2'd2;  // swap: read data into index_a
  localparam logic [1:0] WR_IB_TMP = 2'd3;  // swap: saved entry into index_b

  // Controller to datapath commands
  typedef struct packed {
    logic       load_req;
    logic       ptr_init;
    logic       ptr_step;
    logic       rd_en;
    logic [1:0] rd_src;
    logic       wr_en;
    logic [1:0] wr_src;
    logic       tmp_load;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_ok;
    logic       hit_take;
    logic       mcnt_inc;
    logic       rsp_load;
  } bct_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] mode;
    logic       add_ok;
    logic       del_ok;
    logic       del_tail;
    logic       swap_ok;
    logic       empty;
    logic       rd_vld;
    logic       rd_last;
    logic       hit;
  } bct_sts_t;

endpackage

// ===== rtl/bct_datapath.sv =====
`timescale 1ns / 1ps

module bct_datapath #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  bct_pkg::bct_cmd_t  cmd,
  output bct_pkg::bct_sts_t  sts,
  input  logic [2:0]         mode,
  input  logic [7:0]         index_a,
  input  logic [7:0]         index_b,
  input  logic signed [15:0] entry_id,
  input  logic               collidable,
  input  logic signed [15:0] box_x,
  input  logic signed [15:0] box_y,
  input  logic signed [15:0] box_z,
  input  logic [7:0]         size_x,
  input  logic [7:0]         size_y,
  input  logic [7:0]         size_z,
  input  logic [15:0]        match_mask,
  output logic               ok,
  output logic [7:0]         found_index,
  output logic [8:0]         match_count
);
  import bct_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  typedef struct packed {
    logic [7:0]         sz;
    logic [7:0]         sy;
    logic [7:0]         sx;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic               coll;
    logic [15:0]        id;
  } entry_t;

  // Strict overlap on one axis
  function automatic logic axis_hit(logic signed [15:0] q, logic [7:0] qs,
                                    logic signed [15:0] e, logic [7:0] es);
    logic signed [17:0] q_ext;
    logic signed [17:0] e_ext;
    logic signed [17:0] q_end;
    logic signed [17:0] e_end;
    q_ext = {{2{q[15]}}, q};
    e_ext = {{2{e[15]}}, e};
    q_end = q_ext + $signed({10'd0, qs});
    e_end = e_ext + $signed({10'd0, es});
    return (q_end > e_ext) && (q_ext < e_end);
  endfunction

  // Captured request
  logic [2:0]         req_mode;
  logic [7:0]         req_ia;
  logic [7:0]         req_ib;
  logic signed [15:0] req_id;
  logic               req_coll;
  logic signed [15:0] req_bx;
  logic signed [15:0] req_by;
  logic signed [15:0] req_bz;
  logic [7:0]         req_sx;
  logic [7:0]         req_sy;
  logic [7:0]         req_sz;
  logic [15:0]        req_mask;

  entry_t          mem [CAPACITY];
  entry_t          rd_data;
  entry_t          tmp;
  entry_t          wr_data;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_idx;
  logic            rd_vld;
  logic [AW-1:0]   ptr;
  logic [CW-1:0]   count;
  logic            work_ok;
  logic [AW-1:0]   work_idx;
  logic [8:0]      mcnt;

  logic [AW-1:0]   ia_addr;
  logic [AW-1:0]   ib_addr;
  logic [AW-1:0]   cnt_addr;
  logic [AW-1:0]   last_addr;
  logic [AW-1:0]   end_addr;
  logic            box_hit;
  logic            id_hit;

  assign ia_addr   = AW'(req_ia);
  assign ib_addr   = AW'(req_ib);
  assign cnt_addr  = AW'(count);
  assign last_addr = AW'(count - 1'b1);
  assign end_addr  = (req_mode == MODE_LAST) ? '0 : last_addr;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode <= mode;
      req_ia   <= index_a;
      req_ib   <= index_b;
      req_id   <= entry_id;
      req_coll <= collidable;
      req_bx   <= box_x;
      req_by   <= box_y;
      req_bz   <= box_z;
      req_sx   <= size_x;
      req_sy   <= size_y;
      req_sz   <= size_z;
      req_mask <= match_mask;
    end
  end

  // Address and data selection
  always_comb begin
    case (cmd.rd_src)
      RD_IA:   rd_addr = ia_addr;
      RD_IB:   rd_addr = ib_addr;
      default: rd_addr = ptr;
    endcase
  end

  always_comb begin
    wr_data = rd_data;
    case (cmd.wr_src)
      WR_APPEND: begin
        wr_addr = cnt_addr;
        wr_data = '{sz: req_sz, sy: req_sy, sx: req_sx, z: req_bz, y: req_by,
                    x: req_bx, coll: req_coll, id: req_id};
      end
      WR_SHIFT:  wr_addr = rd_idx - 1'b1;
      WR_IA_RD:  wr_addr = ia_addr;
      WR_IB_TMP: begin
        wr_addr = ib_addr;
        wr_data = tmp;
      end
      default:   wr_addr = ia_addr;
    endcase
  end

  // Entry store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
      rd_idx  <= rd_addr;
    end
    if (cmd.tmp_load) begin
      tmp <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
  end

  // Walk pointer: up from the start (from index_a + 1 for delete), down for last match
  always_ff @(posedge clk) begin
    if (cmd.ptr_init) begin
      case (req_mode)
        MODE_DELETE: ptr <= ia_addr + 1'b1;
        MODE_LAST:   ptr <= last_addr;
        default:     ptr <= '0;
      endcase
    end else if (cmd.ptr_step) begin
      ptr <= (req_mode == MODE_LAST) ? ptr - 1'b1 : ptr + 1'b1;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  // Working result
  always_ff @(posedge clk) begin
    if (rst || cmd.load_req) begin
      work_ok  <= 1'b0;
      work_idx <= '0;
      mcnt     <= '0;
    end else begin
      if (cmd.set_ok) begin
        work_ok <= 1'b1;
      end
      if (cmd.hit_take) begin
        work_ok  <= 1'b1;
        work_idx <= rd_idx;
      end
      if (cmd.mcnt_inc) begin
        mcnt <= mcnt + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      ok          <= work_ok;
      found_index <= 8'(work_idx);
      match_count <= (req_mode == MODE_COUNT) ? mcnt : 9'(count);
    end
  end

  // Match logic on the entry just read
  assign box_hit = rd_data.coll && !rd_data.id[15] &&
                   axis_hit(req_bx, req_sx, rd_data.x, rd_data.sx) &&
                   axis_hit(req_by, req_sy, rd_data.y, rd_data.sy) &&
                   axis_hit(req_bz, req_sz, rd_data.z, rd_data.sz);
  assign id_hit  = ((rd_data.id ^ req_id) & req_mask) == '0;

  // Status
  assign sts.mode     = req_mode;
  assign sts.add_ok   = count < CW'(CAPACITY);
  assign sts.del_ok   = XW'(req_ia) < XW'(count);
  assign sts.del_tail = (XW'(req_ia) + 1'b1) == XW'(count);
  assign sts.swap_ok  = (XW'(req_ia) < XW'(count)) && (XW'(req_ib) < XW'(count));
  assign sts.empty    = count == '0;
  assign sts.rd_vld   = rd_vld;
  assign sts.rd_last  = rd_vld && (rd_idx == end_addr);
  assign sts.hit      = (req_mode == MODE_BOX) ? box_hit : id_hit;

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> count < CW'(CAPACITY))
    else $error("append past capacity");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> count != '0)
    else $error("delete on empty table");

  a_shift_src: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.wr_src == WR_SHIFT) |-> (rd_vld && rd_idx != '0))
    else $error("shift write without valid read data");
`endif

endmodule

// ===== rtl/bct_ctrl.sv =====
`timescale 1ns / 1ps

module bct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bct_pkg::bct_cmd_t cmd,
  input  bct_pkg::bct_sts_t sts
);
  import bct_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_SHIFT    = 3'd3;
  localparam logic [2:0] ST_SWP1     = 3'd4;
  localparam logic [2:0] ST_SWP2     = 3'd5;
  localparam logic [2:0] ST_SWP3     = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == ST_IDLE);

  // Sequencing
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_DONE;
        case (sts.mode)
          MODE_ADD: begin
            if (sts.add_ok) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = WR_APPEND;
              cmd.cnt_inc = 1'b1;
              cmd.set_ok  = 1'b1;
            end
          end
          MODE_DELETE: begin
            if (sts.del_ok && sts.del_tail) begin
              cmd.cnt_dec = 1'b1;
              cmd.set_ok  = 1'b1;
            end else if (sts.del_ok) begin
              cmd.ptr_init = 1'b1;
              state_next   = ST_SHIFT;
            end
          end
          MODE_SWAP: begin
            if (sts.swap_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_IA;
              state_next = ST_SWP1;
            end
          end
          MODE_BOX, MODE_COUNT, MODE_FIRST, MODE_LAST: begin
            if (!sts.empty) begin
              cmd.ptr_init = 1'b1;
              state_next   = ST_SCAN;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      // One entry read per cycle, evaluated in the next cycle
      ST_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_src   = RD_PTR;
        cmd.ptr_step = 1'b1;
        if (sts.rd_vld) begin
          if (sts.mode == MODE_COUNT) begin
            if (sts.hit) begin
              cmd.mcnt_inc = 1'b1;
              cmd.set_ok   = 1'b1;
            end
            if (sts.rd_last) begin
              state_next = ST_DONE;
            end
          end else if (sts.hit) begin
            cmd.hit_take = 1'b1;
            state_next   = ST_DONE;
          end else if (sts.rd_last) begin
            state_next = ST_DONE;
          end
        end
      end
      // Close the gap: entry i+1 written to slot i
      ST_SHIFT: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_src   = RD_PTR;
        cmd.ptr_step = 1'b1;
        if (sts.rd_vld) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WR_SHIFT;
          if (sts.rd_last) begin
            cmd.cnt_dec = 1'b1;
            cmd.set_ok  = 1'b1;
            state_next  = ST_DONE;
          end
        end
      end
      ST_SWP1: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_src   = RD_IB;
        cmd.tmp_load = 1'b1;
        state_next   = ST_SWP2;
      end
      ST_SWP2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_IA_RD;
        state_next = ST_SWP3;
      end
      ST_SWP3: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_IB_TMP;
        cmd.set_ok = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.rsp_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_DISPATCH))
    else $error("accepted request not dispatched");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.rsp_load |=> (rsp_valid && state == ST_IDLE))
    else $error("loaded response not presented");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (!cmd.wr_en && !cmd.rd_en && !cmd.cnt_inc && !cmd.cnt_dec))
    else $error("table access while idle");
`endif

endmodule

// ===== rtl/box_collision_table.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// request   req_valid / req_ready  mode index_a index_b entry_id collidable
//                                  box_x box_y box_z size_x size_y size_z match_mask
// response  rsp_valid / rsp_ready  ok found_index match_count
//
// One request at a time. Delete at index i below the tail shifts each later entry
// down one slot (at the tail only the count drops); queries walk the table from
// the entry store, reading one entry per cycle.
// Reset (rst, synchronous) clears the entry count; the store needs no clearing.
// A finished response is held in an output register; the next request is taken
// while it waits, and that request's response waits in its last state.

module box_collision_table #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         mode,
  input  logic [7:0]         index_a,
  input  logic [7:0]         index_b,
  input  logic signed [15:0] entry_id,
  input  logic               collidable,
  input  logic signed [15:0] box_x,
  input  logic signed [15:0] box_y,
  input  logic signed [15:0] box_z,
  input  logic [7:0]         size_x,
  input  logic [7:0]         size_y,
  input  logic [7:0]         size_z,
  input  logic [15:0]        match_mask,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic               ok,
  output logic [7:0]         found_index,
  output logic [8:0]         match_count
);
  import bct_pkg::*;

  bct_cmd_t cmd;
  bct_sts_t sts;

  bct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bct_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .index_a     (index_a),
    .index_b     (index_b),
    .entry_id    (entry_id),
    .collidable  (collidable),
    .box_x       (box_x),
    .box_y       (box_y),
    .box_z       (box_z),
    .size_x      (size_x),
    .size_y      (size_y),
    .size_z      (size_z),
    .match_mask  (match_mask),
    .ok          (ok),
    .found_index (found_index),
    .match_count (match_count)
  );

endmodule
